FILE: design/hidkbd_pkg.sv
// Package for the boot keyboard report builder.
// Holds the usage codes, modifier scancode range and default sizes.
// No dependencies.
`default_nettype none

package hidkbd_pkg;

  localparam int unsigned KEY_COUNT_DEF    = 102;
  localparam int unsigned REPORT_SLOTS_DEF = 6;
  localparam int unsigned OUT_SLOTS        = 6;

  localparam logic [7:0] CODE_EMPTY    = 8'h00;
  localparam logic [7:0] CODE_ROLLOVER = 8'h01;
  localparam logic [7:0] CODE_CAPS     = 8'h39;
  localparam logic [7:0] CODE_NUM      = 8'h53;

  localparam logic [8:0] MOD_FIRST = 9'd224;
  localparam logic [8:0] MOD_LAST  = 9'd231;

  typedef logic [7:0] usage_t;

endpackage

`default_nettype wire

FILE: design/hid_boot_keyboard_report_builder.sv
// Boot keyboard report builder with the held-key map in a one-bit synchronous memory.
// Flow: the lock report follows the transfer in the next cycle; the key report is shown
// in OUT after the SCAN (one map entry per cycle) and DRAIN states, behind LOCK with a lock
// report. Busy holds off new events until the key report; filtered events are dropped while idle.
// Reset clears the map through per-entry valid bits and clears the lock flag; the receiver
// cannot stall results. Depends on hidkbd_pkg.
`default_nettype none

module hid_boot_keyboard_report_builder #(
  parameter int unsigned KEY_COUNT    = hidkbd_pkg::KEY_COUNT_DEF,
  parameter int unsigned REPORT_SLOTS = hidkbd_pkg::REPORT_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [8:0]          key_code_i,
  input  wire logic                key_down_i,
  input  wire logic                is_repeat_i,
  input  wire logic [7:0]          modifier_bits_i,
  input  wire logic                caps_locked_i,
  input  wire logic                num_locked_i,
  output logic                     result_valid_o,
  output hidkbd_pkg::usage_t       report_modifiers_o,
  output hidkbd_pkg::usage_t       slot_zero_o,
  output hidkbd_pkg::usage_t       slot_one_o,
  output hidkbd_pkg::usage_t       slot_two_o,
  output hidkbd_pkg::usage_t       slot_three_o,
  output hidkbd_pkg::usage_t       slot_four_o,
  output hidkbd_pkg::usage_t       slot_five_o,
  output logic                     is_lock_report_o,
  output logic                     last_of_run_o
);
  import hidkbd_pkg::*;

  localparam int unsigned AW = $clog2(KEY_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_COUNT - 1);
  localparam logic [2:0] SLOT_LIMIT = 3'(REPORT_SLOTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOCK  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                synced_q, synced_d;
  logic [AW-1:0]       rd_addr_q, rd_addr_d;
  logic                proc_vld_q;
  logic [AW-1:0]       proc_idx_q;
  logic                rd_bit_q;
  logic                rd_vld_q;
  logic [2:0]          cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  usage_t              mods_q, mods_d;
  usage_t              slot_q [OUT_SLOTS];
  usage_t              slot_d [OUT_SLOTS];
  usage_t              lock_slot [OUT_SLOTS];

  logic                map_mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] map_vld_q;

  logic in_map, in_mods, evt_ok, evt_take, need_lock, held;

  assign busy      = (state_q != ST_IDLE);
  assign in_map    = (key_code_i < 9'(KEY_COUNT));
  assign in_mods   = (key_code_i >= MOD_FIRST) && (key_code_i <= MOD_LAST);
  assign evt_ok    = !is_repeat_i && (in_map || in_mods);
  assign evt_take  = start && !busy && evt_ok;
  assign need_lock = !synced_q && (caps_locked_i || num_locked_i);
  assign held      = rd_vld_q && rd_bit_q;

  always_comb begin
    for (int k = 0; k < OUT_SLOTS; k++) begin
      lock_slot[k] = CODE_EMPTY;
    end
    if (caps_locked_i) begin
      lock_slot[0] = CODE_CAPS;
      if (num_locked_i && REPORT_SLOTS > 1) begin
        lock_slot[1] = CODE_NUM;
      end
    end else if (num_locked_i) begin
      lock_slot[0] = CODE_NUM;
    end
  end

  always_comb begin
    state_d   = state_q;
    synced_d  = synced_q;
    rd_addr_d = rd_addr_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    mods_d    = mods_q;
    slot_d    = slot_q;

    if (proc_vld_q && held && !ovf_q) begin
      if (cnt_q >= SLOT_LIMIT) begin
        ovf_d = 1'b1;
        for (int k = 0; k < OUT_SLOTS; k++) begin
          if (k < REPORT_SLOTS) begin
            slot_d[k] = CODE_ROLLOVER;
          end
        end
      end else begin
        slot_d[cnt_q] = 8'(proc_idx_q);
        cnt_d = cnt_q + 3'd1;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (evt_take) begin
          synced_d  = 1'b1;
          mods_d    = modifier_bits_i;
          rd_addr_d = '0;
          cnt_d     = '0;
          ovf_d     = 1'b0;
          for (int k = 0; k < OUT_SLOTS; k++) begin
            slot_d[k] = need_lock ? lock_slot[k] : CODE_EMPTY;
          end
          state_d = need_lock ? ST_LOCK : ST_SCAN;
        end
      end
      ST_LOCK: begin
        for (int k = 0; k < OUT_SLOTS; k++) begin
          slot_d[k] = CODE_EMPTY;
        end
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_addr_q == LAST_ADDR) begin
          state_d = ST_DRAIN;
        end else begin
          rd_addr_d = rd_addr_q + AW'(1);
        end
      end
      ST_DRAIN: state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      synced_q   <= 1'b0;
      rd_addr_q  <= '0;
      proc_vld_q <= 1'b0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      map_vld_q  <= '0;
    end else begin
      state_q    <= state_d;
      synced_q   <= synced_d;
      rd_addr_q  <= rd_addr_d;
      proc_vld_q <= (state_q == ST_SCAN);
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      if (evt_take && in_map) begin
        map_vld_q[key_code_i[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mods_q     <= mods_d;
    slot_q     <= slot_d;
    proc_idx_q <= rd_addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (evt_take && in_map) begin
      map_mem[key_code_i[AW-1:0]] <= key_down_i;
    end
    rd_bit_q <= map_mem[rd_addr_q];
    rd_vld_q <= map_vld_q[rd_addr_q];
  end

  assign result_valid_o     = (state_q == ST_LOCK) || (state_q == ST_OUT);
  assign is_lock_report_o   = (state_q == ST_LOCK);
  assign last_of_run_o      = (state_q == ST_OUT);
  assign report_modifiers_o = (state_q == ST_LOCK) ? CODE_EMPTY : mods_q;
  assign slot_zero_o        = slot_q[0];
  assign slot_one_o         = slot_q[1];
  assign slot_two_o         = slot_q[2];
  assign slot_three_o       = slot_q[3];
  assign slot_four_o        = slot_q[4];
  assign slot_five_o        = slot_q[5];

  a_lock_follows_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_lock_report_o |-> $past(start && !busy))
    else $error("Lock report without a preceding input transfer.");

  a_lock_then_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_lock_report_o |=> busy && !result_valid_o)
    else $error("Lock report not followed by the map scan.");

  a_idle_after_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(result_valid_o && last_of_run_o))
    else $error("Block went idle without a final report.");

  a_slot_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SLOT_LIMIT)
    else $error("Slot count exceeds the report slots.");

endmodule

`default_nettype wire
